// ----- src/moving_average_filter_defines.svh -----
// Assertion macros for the moving average filter.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef MOVING_AVERAGE_FILTER_DEFINES_SVH
`define MOVING_AVERAGE_FILTER_DEFINES_SVH

// check cons in the same cycle as ante
`define MAF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("moving_average_filter: check failed");

// check cons in the cycle after ante
`define MAF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("moving_average_filter: check failed");

`endif

// ----- src/maf_pkg.sv -----
// Shared constants, types and helpers of the moving average filter.
// No dependencies; imported by the top level, the divider and the testbench.
package maf_pkg;

    localparam int MAX_WINDOW   = 64;
    localparam int SAMPLE_WIDTH = 16;
    localparam int CFG_WIDTH    = 7;
    localparam int WINDOW_RESET = 16;

    localparam int ADDR_WIDTH = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WLEN_WIDTH = ADDR_WIDTH + 1;
    localparam int SUM_WIDTH  = SAMPLE_WIDTH + ADDR_WIDTH;
    localparam int CNT_WIDTH  = $clog2(SUM_WIDTH);

    typedef struct packed {
        logic                  start;
        logic [SUM_WIDTH-1:0]  dividend;
        logic [WLEN_WIDTH-1:0] divisor;
    } maf_div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } maf_div_stat_t;

    function automatic logic [WLEN_WIDTH-1:0] eff_window(input logic [CFG_WIDTH-1:0] wl);
        logic [WLEN_WIDTH-1:0] res;
        if (wl == '0) begin
            res = WLEN_WIDTH'(1);
        end else if (int'(wl) > MAX_WINDOW) begin
            res = WLEN_WIDTH'(MAX_WINDOW);
        end else begin
            res = WLEN_WIDTH'(wl);
        end
        return res;
    endfunction

endpackage

// ----- src/moving_average_filter.sv -----
// Moving average (boxcar) filter: each request carries one signed sample; once a
// window's worth of samples of the current series has arrived, every sample yields
// one average, the floor of the window sum divided by the window length. From
// acceptance to result, the delay line RAM is read at acceptance, the UPDATE state
// updates the running sum, the bit-serial divider, which handles one request at a
// time, produces SUM_WIDTH (22) quotient bits, and the output register is loaded;
// then the block is ready for the next sample. Samples that yield no result free
// the block after the UPDATE state. A finished average waits in the output
// register while the next sample is taken in. Writing the window length restarts
// the series; no clearing pass is needed after reset.
`include "moving_average_filter_defines.svh"

module moving_average_filter
    import maf_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_WIDTH-1:0]           cfg_window_len,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample,
    input  logic                           s_start_req,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_average
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_UPDATE = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_HOLD   = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [WLEN_WIDTH-1:0]         wlen_reg, wlen_next;
    logic signed [SUM_WIDTH-1:0]   sum_reg, sum_next;
    logic [WLEN_WIDTH-1:0]         fill_reg, fill_next;
    logic [ADDR_WIDTH-1:0]         wp_reg, wp_next;
    logic                          m_valid_reg, m_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] m_average_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic                          start_reg;
    logic [ADDR_WIDTH-1:0]         slot_reg;
    logic                          neg_reg;

    logic                          s_accept;
    logic                          cfg_accept;
    logic [ADDR_WIDTH-1:0]         rd_addr;
    logic [SAMPLE_WIDTH-1:0]       rd_data;
    logic signed [SUM_WIDTH-1:0]   sum_base;
    logic signed [SUM_WIDTH-1:0]   drop;
    logic signed [SUM_WIDTH-1:0]   sum_new;
    logic [WLEN_WIDTH-1:0]         fill_base;
    logic [WLEN_WIDTH-1:0]         fill_new;
    logic [WLEN_WIDTH-1:0]         slot_inc;
    logic                          emit;
    logic                          load_out;
    maf_div_cmd_t                  div_cmd;
    maf_div_stat_t                 div_stat;
    logic [SUM_WIDTH-1:0]          quotient;
    logic [SAMPLE_WIDTH-1:0]       avg;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign rd_addr    = s_start_req ? '0 : wp_reg;

    maf_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_WINDOW)
    ) u_history (
        .aclk    (aclk),
        .wr_en   (state_reg == ST_UPDATE),
        .wr_addr (slot_reg),
        .wr_data (x_reg),
        .rd_en   (s_accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // running sum update with the sample leaving the window
    always_comb begin
        sum_base  = start_reg ? '0 : sum_reg;
        fill_base = start_reg ? '0 : fill_reg;
        drop      = (fill_base >= wlen_reg) ? SUM_WIDTH'(signed'(rd_data)) : '0;
        sum_new   = sum_base - drop + SUM_WIDTH'(x_reg);
        fill_new  = (fill_base < wlen_reg) ? fill_base + WLEN_WIDTH'(1) : fill_base;
        slot_inc  = WLEN_WIDTH'(slot_reg) + WLEN_WIDTH'(1);
        emit      = (fill_new >= wlen_reg);
    end

    always_comb begin
        div_cmd.start    = (state_reg == ST_UPDATE) && emit;
        div_cmd.dividend = sum_new[SUM_WIDTH-1] ? ~sum_new : sum_new;
        div_cmd.divisor  = wlen_reg;
    end

    maf_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (div_cmd),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign avg      = neg_reg ? ~quotient[SAMPLE_WIDTH-1:0] : quotient[SAMPLE_WIDTH-1:0];
    assign load_out = (((state_reg == ST_DIV) && div_stat.done) || (state_reg == ST_HOLD))
                      && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        wlen_next    = wlen_reg;
        sum_next     = sum_reg;
        fill_next    = fill_reg;
        wp_next      = wp_reg;
        m_valid_next = m_valid_reg;

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                sum_next   = sum_new;
                fill_next  = fill_new;
                wp_next    = (slot_inc >= wlen_reg) ? '0 : slot_inc[ADDR_WIDTH-1:0];
                state_next = emit ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = load_out ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_accept) begin
            wlen_next = eff_window(cfg_window_len);
            sum_next  = '0;
            fill_next = '0;
            wp_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wlen_reg    <= WLEN_WIDTH'(WINDOW_RESET);
            sum_reg     <= '0;
            fill_reg    <= '0;
            wp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wlen_reg    <= wlen_next;
            sum_reg     <= sum_next;
            fill_reg    <= fill_next;
            wp_reg      <= wp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            x_reg     <= s_sample;
            start_reg <= s_start_req;
            slot_reg  <= rd_addr;
        end
        if (div_cmd.start) begin
            neg_reg <= sum_new[SUM_WIDTH-1];
        end
        if (load_out) begin
            m_average_reg <= avg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_average = m_average_reg;

    `MAF_ASSERT_SAME(a_idle_div_quiet, state_reg == ST_IDLE, !div_stat.busy)
    `MAF_ASSERT_SAME(a_done_in_div, div_stat.done, state_reg == ST_DIV)
    `MAF_ASSERT_SAME(a_ptr_in_window, 1'b1,
                     (WLEN_WIDTH'(wp_reg) < wlen_reg) && (fill_reg <= wlen_reg))
    `MAF_ASSERT_NEXT(a_accept_update, s_valid && s_ready, state_reg == ST_UPDATE)

endmodule

// ----- src/maf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module maf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/maf_divider.sv -----
// Bit-serial restoring divider: one quotient bit per cycle, SUM_WIDTH quotient bits.
// Depends on maf_pkg for widths and the command/status structs.
module maf_divider
    import maf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  maf_div_cmd_t         cmd,
    output maf_div_stat_t        stat,
    output logic [SUM_WIDTH-1:0] quotient
);

    localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(SUM_WIDTH - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_WIDTH-1:0]  cnt_reg;
    logic [SUM_WIDTH-1:0]  dvd_reg;
    logic [WLEN_WIDTH-1:0] rem_reg;
    logic [WLEN_WIDTH-1:0] dsr_reg;
    logic [WLEN_WIDTH:0]   trial;
    logic [WLEN_WIDTH:0]   diff;
    logic                  fits;

    always_comb begin
        trial = {rem_reg, dvd_reg[SUM_WIDTH-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_WIDTH'(1);
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift one dividend bit into the remainder, one quotient bit out
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            dvd_reg <= cmd.dividend;
            rem_reg <= '0;
            dsr_reg <= cmd.divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[WLEN_WIDTH-1:0] : trial[WLEN_WIDTH-1:0];
            dvd_reg <= {dvd_reg[SUM_WIDTH-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dvd_reg;

endmodule

// ----- bench/moving_average_filter_tb.sv -----
// Self-checking testbench for the moving_average_filter boxcar filter.
// Sends sample requests, predicts each window average and checks every result.
// Depends on maf_pkg and the moving_average_filter top level only.
`timescale 1ns / 100ps

module moving_average_filter_tb
    import maf_pkg::*;
();

    localparam int ITEM_TARGET  = 1800;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 40;
    localparam int TIMEOUT_NS   = 2_000_000;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [CFG_WIDTH-1:0]           cfg_window_len;
    logic                           s_valid;
    logic                           s_ready;
    logic signed [SAMPLE_WIDTH-1:0] s_sample;
    logic                           s_start_req;
    logic                           m_valid;
    logic                           m_ready;
    logic signed [SAMPLE_WIDTH-1:0] m_average;

    logic signed [SAMPLE_WIDTH-1:0] delay_line [MAX_WINDOW];
    logic signed [SUM_WIDTH-1:0]    win_sum  = '0;
    int                             fill_cnt = 0;
    int                             wr_ptr   = 0;
    int                             win_eff  = WINDOW_RESET;

    logic signed [SAMPLE_WIDTH-1:0] expected_averages [$];
    logic signed [SAMPLE_WIDTH-1:0] want_avg;

    int  mismatches      = 0;
    int  items_sent      = 0;
    int  averages_seen   = 0;
    int  window_writes   = 0;
    bit  tx_idle         = 1'b1;
    bit  rx_idle         = 1'b1;
    bit  hold_req        = 1'b0;

    moving_average_filter u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_window_len(cfg_window_len),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .s_start_req   (s_start_req),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_average     (m_average)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("moving_average_filter_tb failed");
        $finish;
    end

    function automatic void restart_series();
        win_sum  = '0;
        fill_cnt = 0;
        wr_ptr   = 0;
    endfunction

    function automatic void predict_average(input logic signed [SAMPLE_WIDTH-1:0] x,
                                            input logic start);
        int slot;
        int sum_int;
        int quo;
        if (start) begin
            restart_series();
        end
        slot = (wr_ptr >= win_eff) ? 0 : wr_ptr;
        if (fill_cnt >= win_eff) begin
            win_sum = win_sum - delay_line[slot];
        end
        win_sum = win_sum + x;
        delay_line[slot] = x;
        wr_ptr = (slot + 1 >= win_eff) ? 0 : slot + 1;
        if (fill_cnt < win_eff) begin
            fill_cnt++;
        end
        if (fill_cnt >= win_eff) begin
            sum_int = win_sum;
            quo = sum_int / win_eff;
            if ((sum_int % win_eff) != 0 && sum_int < 0) begin
                quo--;
            end
            expected_averages.push_back(SAMPLE_WIDTH'(quo));
        end
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
        logic signed [SAMPLE_WIDTH-1:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'sh7fff;
            1: v = 16'sh8000;
            2: v = SAMPLE_WIDTH'(int'($urandom_range(0, 8)) - 4);
            default: v = SAMPLE_WIDTH'($urandom);
        endcase
        return v;
    endfunction

    // check every accepted average against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            averages_seen++;
            if (expected_averages.size() == 0) begin
                mismatches++;
                $display("%0t: average %0d arrived, expected none", $time, m_average);
            end else begin
                want_avg = expected_averages.pop_front();
                if (m_average !== want_avg) begin
                    mismatches++;
                    $display("%0t: average mismatch, expected %0d, actual %0d",
                             $time, want_avg, m_average);
                end
            end
        end
    end

    // result side: random stall per result, long hold when asked
    initial begin
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                stall = rx_idle ? $urandom_range(0, 6) : 0;
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_ready <= 1'b1;
                @(posedge aclk);
                while (!(m_valid && m_ready) && !hold_req) @(posedge aclk);
            end
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] value,
                               input logic start);
        int gap;
        gap = tx_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample    <= value;
        s_start_req <= start;
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
        predict_average(value, start);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_averages.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(input logic [CFG_WIDTH-1:0] code);
        wait_idle();
        cfg_valid      <= 1'b1;
        cfg_window_len <= code;
        @(posedge aclk);
        while (!(cfg_valid && cfg_ready)) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (code == '0) begin
            win_eff = 1;
        end else if (int'(code) > MAX_WINDOW) begin
            win_eff = MAX_WINDOW;
        end else begin
            win_eff = int'(code);
        end
        restart_series();
        window_writes++;
    endtask

    // reset window, series continued without a start, extremes and floor of -1/2
    task automatic test_default_window();
        int i;
        for (i = 0; i < 16; i++) begin
            send_sample((i % 2) ? 16'sh8000 : 16'sh7fff, 1'b0);
        end
        send_sample(-16'sd1, 1'b0);
    endtask

    task automatic test_window_zero();
        write_window(7'd0);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh7fff, 1'b0);
        send_sample(-16'sd1, 1'b0);
    endtask

    task automatic test_window_two();
        write_window(7'd2);
        send_sample(-16'sd1, 1'b1);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd3, 1'b0);
        send_sample(-16'sd2, 1'b1);
        send_sample(16'sd1, 1'b0);
    endtask

    task automatic test_output_hold();
        int i;
        write_window(7'd1);
        tx_idle  = 1'b0;
        hold_req = 1'b1;
        for (i = 0; i < 12; i++) begin
            send_sample(rand_sample(), 1'b0);
        end
        tx_idle = 1'b1;
    endtask

    task automatic test_sender_pause();
        int i;
        write_window(7'd4);
        for (i = 0; i < 10; i++) begin
            send_sample(rand_sample(), i == 0);
        end
        s_valid <= 1'b0;
        while (expected_averages.size() != 0) @(posedge aclk);
        for (i = 0; i < 10; i++) begin
            send_sample(rand_sample(), 1'b0);
        end
    endtask

    task automatic test_random_series();
        int phase;
        int code;
        int nseries;
        int len;
        int s;
        int k;
        bit fresh;
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            phase++;
            if (phase == 1) begin
                code = 127;
            end else if (phase == 2) begin
                code = 64;
            end else begin
                case ($urandom_range(0, 11))
                    0: code = $urandom_range(65, 127);
                    1: code = 64;
                    2: code = 0;
                    3, 4: code = $urandom_range(9, 40);
                    default: code = $urandom_range(1, 8);
                endcase
            end
            write_window(CFG_WIDTH'(code));
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            nseries = $urandom_range(1, 3);
            for (s = 0; s < nseries; s++) begin
                len   = win_eff + $urandom_range(0, 24);
                fresh = ($urandom_range(0, 5) != 0);
                for (k = 0; k < len; k++) begin
                    send_sample(rand_sample(),
                                (k == 0) ? fresh : ($urandom_range(0, 39) == 0));
                end
            end
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial begin
        aresetn        <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_window_len <= '0;
        s_valid        <= 1'b0;
        s_sample       <= '0;
        s_start_req    <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_default_window();
        test_window_zero();
        test_window_two();
        test_output_hold();
        test_sender_pause();
        test_random_series();
        wait_idle();

        $display("Sent %0d samples, checked %0d averages across %0d window lengths.",
                 items_sent, averages_seen, window_writes);
        $display("Mismatches found: %0d", mismatches);
        if (mismatches == 0) begin
            $display("moving_average_filter_tb passed");
        end else begin
            $display("moving_average_filter_tb failed");
        end
        $finish;
    end

endmodule
